FILE: src/bids_pkg.sv
`default_nettype none

package bids_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int POS_W     = 4;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    localparam logic signed [DATA_W-1:0] DATA_INVALID = -32'sd1;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data_out;
        logic                     found;
        logic [CNT_OUT_W-1:0]     count_out;
    } t_out;

endpackage

`default_nettype wire

FILE: src/bounded_int_deque_with_search.sv
// channel   dir  valid        stall        payload
// command   in   i_in_valid   o_in_stall   i_in  (t_in)
// result    out  o_out_valid  i_out_stall  o_out (t_out)
//
// push, pop and unused codes: the result is loaded at accept
// read at: one registered read of the entry memory, then S_READ loads the result
// search: result loaded at accept when empty, else at most one read per held entry
// reset is synchronous, active low; it empties the deque, memory contents stay
// a busy read or search or a waiting result stalls the input; a command is taken in the cycle it leaves
`default_nettype none

module bounded_int_deque_with_search
    import bids_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_in  i_in,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out      o_out,
    input  wire logic i_out_stall
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SRCH = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [DATA_W-1:0]  r_key, n_key;
    logic               r_found, n_found;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;

    logic               out_free;
    logic               in_accept;
    logic               is_full;
    logic               is_empty;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [SUM_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + offset;
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

    bids_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_in.value),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign is_full    = (r_count == CNT_W'(DEPTH));
    assign is_empty   = (r_count == '0);

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_key       = r_key;
        n_found     = r_found;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_head;
        mem_re      = 1'b0;
        mem_raddr   = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_out.status   = ST_OK;
                    n_out.data_out = '0;
                    n_out.found    = 1'b0;
                    n_out_valid    = 1'b1;
                    unique case (i_in.command)
                        CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                n_head    = (r_head == '0) ? IDX_W'(DEPTH - 1)
                                                           : r_head - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = n_head;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (is_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = slot_of(r_head, SUM_W'(r_count));
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (is_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_head  = slot_of(r_head, SUM_W'(1));
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (is_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_SEARCH: begin
                            if (!is_empty) begin
                                // walk from the front, one read per cycle
                                n_out_valid = r_out_valid && i_out_stall;
                                n_out       = r_out;
                                mem_re      = 1'b1;
                                mem_raddr   = r_head;
                                n_idx       = CNT_W'(1);
                                n_key       = i_in.value;
                                n_state     = S_SRCH;
                            end
                        end
                        CMD_READ_AT: begin
                            if (32'(i_in.position) >= 32'(r_count)) begin
                                n_out.status   = ST_BADPOS;
                                n_out.data_out = DATA_INVALID;
                            end else begin
                                n_out_valid = r_out_valid && i_out_stall;
                                n_out       = r_out;
                                mem_re      = 1'b1;
                                mem_raddr   = slot_of(r_head, SUM_W'(i_in.position));
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.count_out = CNT_OUT_W'(n_count);
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_out.status    = ST_OK;
                    n_out.data_out  = mem_rdata;
                    n_out.found     = 1'b0;
                    n_out.count_out = CNT_OUT_W'(r_count);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SRCH: begin
                if (mem_rdata == r_key) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (r_idx == r_count) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = slot_of(r_head, SUM_W'(r_idx));
                    n_idx     = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.status    = ST_OK;
                    n_out.data_out  = '0;
                    n_out.found     = r_found;
                    n_out.count_out = CNT_OUT_W'(r_count);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_key   <= n_key;
        r_found <= n_found;
        r_out   <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !is_full &&
         (i_in.command == CMD_PUSH_FRONT || i_in.command == CMD_PUSH_BACK))
        |=> (r_out.status == ST_OK) && (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not grow the deque");

    a_busy_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_count == $past(r_count)) && (r_head == $past(r_head)))
        else $error("deque state moved during a read or search");

endmodule

`default_nettype wire

FILE: src/bids_ram.sv
`default_nettype none

module bids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]               i_wdata,
    input  wire logic                           i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/bids_deque_checker.sv
`timescale 1ns / 100ps

module bids_deque_checker
    import bids_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_stall,
    input  wire t_in  i_in,
    input  wire logic i_out_valid,
    input  wire logic i_out_stall,
    input  wire t_out i_out,
    output int        o_errors,
    output int        o_pending
);

    // predicted deque contents, front at front_idx
    logic signed [DATA_W-1:0] words [DEPTH];
    logic [IDX_W-1:0]         front_idx;
    logic [CNT_W-1:0]         held;

    t_out expected_results [$];
    int   error_total;
    int   result_num;

    initial begin
        error_total = 0;
        result_num  = 0;
    end

    function automatic logic [IDX_W-1:0] slot_at(input int offset);
        return IDX_W'((int'(front_idx) + offset) % DEPTH);
    endfunction

    function automatic t_out deque_apply(input t_in item);
        t_out r;
        r = '0;
        case (item.command)
            CMD_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    front_idx = slot_at(DEPTH - 1);
                    words[front_idx] = item.value;
                    held = held + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    words[slot_at(int'(held))] = item.value;
                    held = held + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    front_idx = slot_at(1);
                    held = held - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    held = held - 1'b1;
                end
            end
            CMD_SEARCH: begin
                // front first, first hit ends the walk
                for (int i = 0; i < int'(held); i++) begin
                    if (words[slot_at(i)] == item.value) begin
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            CMD_READ_AT: begin
                if (int'(item.position) >= int'(held)) begin
                    r.status   = ST_BADPOS;
                    r.data_out = DATA_INVALID;
                end else begin
                    r.data_out = words[slot_at(int'(item.position))];
                end
            end
            default: begin
            end
        endcase
        r.count_out = CNT_OUT_W'(held);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: result %0d: %s", $time, result_num, what);
        error_total++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            expected_results.delete();
            front_idx = '0;
            held      = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction %h", i_out));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.status !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_out.status, want.status));
                    end
                    if (i_out.data_out !== want.data_out) begin
                        report_mismatch($sformatf("data_out got %0d want %0d",
                                                  i_out.data_out, want.data_out));
                    end
                    if (i_out.found !== want.found) begin
                        report_mismatch($sformatf("found got %b want %b",
                                                  i_out.found, want.found));
                    end
                    if (i_out.count_out !== want.count_out) begin
                        report_mismatch($sformatf("count_out got %0d want %0d",
                                                  i_out.count_out, want.count_out));
                    end
                end
                result_num++;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(deque_apply(i_in));
            end
        end
        o_pending <= expected_results.size();
        o_errors  <= error_total;
    end

endmodule

FILE: tb/sv/bounded_int_deque_with_search_tb.sv
`timescale 1ns / 100ps

module bounded_int_deque_with_search_tb;
    import bids_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int BURST_ITEMS  = 40;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 40;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } t_mix;

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_item   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_item;

    int errors;
    int pending;
    int idle_cycles = 0;
    bit hold_req    = 1'b0;
    bit hold_active = 1'b0;

    // recent pushed words, so searches hit often
    logic signed [DATA_W-1:0] pushed_words [$];

    bounded_int_deque_with_search dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in        (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out       (out_item),
        .i_out_stall (out_stall)
    );

    bids_deque_checker deque_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_item),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return WORD_MAX;
        if (r < 12) return WORD_MIN;
        if (r < 16) return '0;
        if (r < 20) return -1;
        // small pool gives duplicate words in the deque
        if (r < 45) return $urandom_range(0, 7);
        return $urandom;
    endfunction

    function automatic t_in cmd_item(input logic [CMD_W-1:0] cmd,
                                     input logic signed [DATA_W-1:0] word,
                                     input int pos);
        t_in it;
        it.command  = cmd;
        it.value    = word;
        it.position = POS_W'(pos);
        return it;
    endfunction

    function automatic t_in random_command(input t_mix mix);
        t_in it;
        int  push_pct;
        int  pop_pct;
        int  r;
        case (mix)
            MIX_FILL: begin
                push_pct = 60;
                pop_pct  = 12;
            end
            MIX_DRAIN: begin
                push_pct = 12;
                pop_pct  = 60;
            end
            default: begin
                push_pct = 33;
                pop_pct  = 30;
            end
        endcase
        it.value    = pick_word();
        it.position = POS_W'($urandom_range(0, $urandom_range(0, 1) ? 7 : 15));
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            it.command = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            pushed_words.push_back(it.value);
            if (pushed_words.size() > 32) void'(pushed_words.pop_front());
        end else if (r < push_pct + pop_pct) begin
            it.command = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        end else if (r < 97) begin
            it.command = $urandom_range(0, 1) ? CMD_SEARCH : CMD_READ_AT;
            if (it.command == CMD_SEARCH && pushed_words.size() > 0 && $urandom_range(0, 1)) begin
                it.value = pushed_words[$urandom_range(0, pushed_words.size() - 1)];
            end
        end else begin
            it.command = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
        end
        return it;
    endfunction

    // entered right after an edge; returns at the edge that takes the transaction
    task automatic send_item(input t_in item, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
    endtask

    // result side
    initial begin
        int n;
        bit hold_taken;
        hold_taken = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken  = 1'b1;
                hold_active = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                out_stall <= 1'b0;
                repeat ($urandom_range(40, 120)) @(posedge clk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // command side
    initial begin
        int   sent;
        int   chunk;
        bit   quiet;
        bit   hold_done;
        bit   drain_done;
        t_mix mix;
        logic signed [DATA_W-1:0] word;

        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty deque corner cases
        send_item(cmd_item(CMD_POP_FRONT, -1, 0), pick_gap());
        send_item(cmd_item(CMD_POP_BACK, WORD_MAX, 15), pick_gap());
        send_item(cmd_item(CMD_SEARCH, 0, 0), pick_gap());
        send_item(cmd_item(CMD_READ_AT, WORD_MIN, 15), pick_gap());
        // fill from both ends, extremes among the words
        for (int i = 0; i < DEPTH; i++) begin
            case (i % 4)
                0: word = WORD_MAX;
                1: word = WORD_MIN;
                2: word = -1;
                default: word = i;
            endcase
            send_item(cmd_item(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, word, 0), pick_gap());
        end
        send_item(cmd_item(CMD_PUSH_BACK, 7, 0), pick_gap());
        send_item(cmd_item(CMD_READ_AT, 0, 15), pick_gap());
        send_item(cmd_item(CMD_SEARCH, 13, 0), pick_gap());
        send_item(cmd_item(CMD_POP_BACK, 0, 0), pick_gap());
        send_item(cmd_item(CMD_POP_FRONT, 0, 0), pick_gap());

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mix   = t_mix'($urandom_range(0, 2));
            chunk = $urandom_range(20, 60);
            quiet = ($urandom_range(0, 3) == 0);
            repeat (chunk) begin
                send_item(random_command(mix), quiet ? 0 : pick_gap());
                sent++;
            end
            if (!hold_done && sent >= 300) begin
                // result side holds off while commands keep coming
                hold_done = 1'b1;
                in_valid <= 1'b0;
                hold_req = 1'b1;
                wait (hold_active);
                @(posedge clk);
                repeat (BURST_ITEMS) begin
                    send_item(random_command(MIX_FILL), 0);
                    sent++;
                end
            end
            if (!drain_done && sent >= 650) begin
                drain_done = 1'b1;
                in_valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // stop if the channels go quiet for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
